@@ hw/rtl/frame_rate_pacer_assert.svh @@
// Assertion macros for the frame rate pacer RTL.
`ifndef FRAME_RATE_PACER_ASSERT_SVH
`define FRAME_RATE_PACER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/frp_pkg.sv @@
// Shared constants and types for the frame rate pacer.
package frp_pkg;

  // Field and register widths.
  localparam int TIME_W    = 64;
  localparam int FPS_W     = 10;
  localparam int CATCH_W   = 20;
  localparam int CNT_W     = 16;
  localparam int US_W      = 20;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_SEL_BIT = 2;

  // Register selects on the configuration bus.
  localparam logic REG_TARGET  = 1'b0;
  localparam logic REG_CATCHUP = 1'b1;

  // Register reset values.
  localparam logic [FPS_W-1:0]   TARGET_RST  = 10'd30;
  localparam logic [CATCH_W-1:0] CATCHUP_RST = 20'd50000;

  // Timing constants.
  localparam logic [US_W-1:0] ONE_SEC_US = 20'd1000000;
  localparam logic [US_W-1:0] SLEEP_MAX  = 20'd999999;
  localparam logic [CNT_W-1:0] FC_MAX    = 16'hFFFF;

  // Signed working width of the needed and remaining times.
  localparam int NEED_W = 38;
  localparam int MAG_W  = CNT_W + 1;

  // Serial divider for the needed time.
  localparam int DIV_N_W   = 36;
  localparam int DIV_D_W   = FPS_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Constant division by reciprocal multiplication with one correction.
  localparam int DVX_W       = 23;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = DVX_W + RECIP_W;
  localparam logic [DIV_D_W-1:0] SLEEP_DIV = 10'd5;
  localparam logic [DIV_D_W-1:0] US_PER_MS = 10'd1000;
  localparam logic [RECIP_W-1:0] RECIP_M_SLEEP = RECIP_W'((2 ** RECIP_SHIFT) / 5);
  localparam logic [RECIP_W-1:0] RECIP_M_MS    = RECIP_W'((2 ** RECIP_SHIFT) / 1000);
  localparam logic [DVX_W-1:0]   CLAMP_LIMIT   = 23'd5000000;

  // Divider request and status.
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/frp_if.sv @@
// Valid/ready channel interfaces for the frame rate pacer input and result words.
interface frp_in_if;
  import frp_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] now_us;

  modport source (output valid, kind, now_us, input ready);
  modport sink   (input valid, kind, now_us, output ready);
endinterface

interface frp_out_if;
  import frp_pkg::*;

  logic              valid;
  logic              ready;
  logic              proceed;
  logic [US_W-1:0]   sleep_us;
  logic [US_W-1:0]   delta_us;
  logic [TIME_W-1:0] elapsed_ms;
  logic [CNT_W-1:0]  fps;
  logic              fps_updated;

  modport source (output valid, proceed, sleep_us, delta_us, elapsed_ms, fps, fps_updated,
                  input ready);
  modport sink   (input valid, proceed, sleep_us, delta_us, elapsed_ms, fps, fps_updated,
                  output ready);
endinterface

@@ hw/rtl/frp_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module frp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  frp_pkg::div_req_t req,
  output frp_pkg::div_rsp_t rsp
);
  import frp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   dsr_r, dsr_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     trial_sub;
  logic                 trial_ge;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial     = {rem_r, quo_r[DIV_N_W-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign trial_ge  = trial >= {1'b0, dsr_r};

  // Load on start, otherwise iterate until the last bit is done.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_N_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_N_W-2:0], trial_ge};
      rem_nxt = trial_ge ? trial_sub[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hw/rtl/frame_rate_pacer.sv @@
// Frame rate pacer top level: microcoded sequencer, datapath and APB registers.
// A frame_done word is taken in the idle step and gives no result.
// A pace_check word with pacing on waits on the 36-step divider that forms the needed
// time; with target_fps at zero it skips the pacing steps and goes to the delta steps.
// Synchronous active-low reset restores the register defaults and clears all timing
// state; the block is ready for input as soon as reset is released.
`include "frame_rate_pacer_assert.svh"

module frame_rate_pacer (
  input  logic                         clk,
  input  logic                         rst_n,
  frp_in_if.sink                       in_ch,
  frp_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frp_pkg::PADDR_W-1:0]  paddr,
  input  logic [frp_pkg::APB_W-1:0]    pwdata,
  output logic [frp_pkg::APB_W-1:0]    prdata,
  output logic                         pready
);
  import frp_pkg::*;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_WINDOW,
    OP_SPENT,
    OP_MUL,
    OP_NEEDED,
    OP_CATCH,
    OP_SLEEPCHK,
    OP_RECIP,
    OP_CORR_SLEEP,
    OP_EMIT_SLEEP,
    OP_DELTA,
    OP_CORR_MS,
    OP_EMIT_GO
  } op_t;

  // Sequencing conditions.
  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_IF_NOTGT,
    C_WAIT_DIV,
    C_IF_NOCATCH,
    C_IF_NOSLEEP,
    C_IF_CLAMP,
    C_EMIT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // Step addresses of the program.
  localparam pc_t ST_IDLE       = 4'd0;
  localparam pc_t ST_WINDOW     = 4'd1;
  localparam pc_t ST_SPENT      = 4'd2;
  localparam pc_t ST_MUL        = 4'd3;
  localparam pc_t ST_NEEDED     = 4'd4;
  localparam pc_t ST_CATCH      = 4'd5;
  localparam pc_t ST_RESPENT    = 4'd6;
  localparam pc_t ST_SLEEPCHK   = 4'd7;
  localparam pc_t ST_RECIP_SLP  = 4'd8;
  localparam pc_t ST_CORR_SLP   = 4'd9;
  localparam pc_t ST_EMIT_SLEEP = 4'd10;
  localparam pc_t ST_DELTA      = 4'd11;
  localparam pc_t ST_RECIP_MS   = 4'd12;
  localparam pc_t ST_CORR_MS    = 4'd13;
  localparam pc_t ST_EMIT_GO    = 4'd14;
  localparam pc_t ST_SPARE      = 4'd15;

  // Constant divisor select.
  localparam logic DSEL_SLEEP = 1'b0;
  localparam logic DSEL_MS    = 1'b1;

  // Control store.
  function automatic ucode_t ucode_rom(input pc_t addr);
    ucode_t w;
    case (addr)
      ST_IDLE:       w = '{op: OP_IDLE,       cond: C_WAIT_IN,    target: ST_IDLE};
      ST_WINDOW:     w = '{op: OP_WINDOW,     cond: C_IF_NOTGT,   target: ST_DELTA};
      ST_SPENT:      w = '{op: OP_SPENT,      cond: C_NEXT,       target: ST_IDLE};
      ST_MUL:        w = '{op: OP_MUL,        cond: C_NEXT,       target: ST_IDLE};
      ST_NEEDED:     w = '{op: OP_NEEDED,     cond: C_WAIT_DIV,   target: ST_IDLE};
      ST_CATCH:      w = '{op: OP_CATCH,      cond: C_IF_NOCATCH, target: ST_SLEEPCHK};
      ST_RESPENT:    w = '{op: OP_SPENT,      cond: C_NEXT,       target: ST_IDLE};
      ST_SLEEPCHK:   w = '{op: OP_SLEEPCHK,   cond: C_IF_NOSLEEP, target: ST_DELTA};
      ST_RECIP_SLP:  w = '{op: OP_RECIP,      cond: C_IF_CLAMP,   target: ST_EMIT_SLEEP};
      ST_CORR_SLP:   w = '{op: OP_CORR_SLEEP, cond: C_NEXT,       target: ST_IDLE};
      ST_EMIT_SLEEP: w = '{op: OP_EMIT_SLEEP, cond: C_EMIT,       target: ST_IDLE};
      ST_DELTA:      w = '{op: OP_DELTA,      cond: C_NEXT,       target: ST_IDLE};
      ST_RECIP_MS:   w = '{op: OP_RECIP,      cond: C_NEXT,       target: ST_IDLE};
      ST_CORR_MS:    w = '{op: OP_CORR_MS,    cond: C_NEXT,       target: ST_IDLE};
      ST_EMIT_GO:    w = '{op: OP_EMIT_GO,    cond: C_EMIT,       target: ST_IDLE};
      ST_SPARE:      w = '{op: OP_NOP,        cond: C_JUMP,       target: ST_IDLE};
      default:       w = '{op: OP_NOP,        cond: C_JUMP,       target: ST_IDLE};
    endcase
    return w;
  endfunction

  // Configuration and sequencer state.
  logic [FPS_W-1:0]   target_r, target_nxt;
  logic [CATCH_W-1:0] catchup_r, catchup_nxt;
  pc_t                pc_r, pc_nxt;
  pc_t                pc_inc;
  ucode_t             cw;

  // Timing state.
  logic [TIME_W-1:0]  ws_r, ws_nxt;
  logic [TIME_W-1:0]  ps_r, ps_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic [US_W-1:0]    spent_r, spent_nxt;
  logic [US_W-1:0]    last_spent_r, last_spent_nxt;
  logic [US_W-1:0]    last_delta_r, last_delta_nxt;
  logic [TIME_W-1:0]  ems_r, ems_nxt;

  // Working registers.
  logic [TIME_W-1:0]        now_r, now_nxt;
  logic [CNT_W-1:0]         fps_r, fps_nxt;
  logic                     upd_r, upd_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [NEED_W-1:0] needed_r, needed_nxt;
  logic [DVX_W-1:0]         dvx_r, dvx_nxt;
  logic                     dsel_r, dsel_nxt;
  logic [US_W-1:0]          qest_r, qest_nxt;
  logic                     clamp_r, clamp_nxt;
  logic [US_W-1:0]          sleep_r, sleep_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_proceed_r, out_proceed_nxt;
  logic [US_W-1:0]   out_sleep_r, out_sleep_nxt;
  logic [US_W-1:0]   out_delta_r, out_delta_nxt;
  logic [TIME_W-1:0] out_ems_r, out_ems_nxt;
  logic [CNT_W-1:0]  out_fps_r, out_fps_nxt;
  logic              out_upd_r, out_upd_nxt;

  // Combinational datapath.
  logic                     in_acc;
  logic                     cfg_wr;
  logic                     out_free;
  logic                     emit;
  logic [TIME_W-1:0]        win_diff;
  logic                     win_hit;
  logic [TIME_W-1:0]        ws_step;
  logic [TIME_W-1:0]        pace_diff;
  logic [US_W-1:0]          spent_calc;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W+US_W-1:0]    num_full;
  logic signed [NEED_W-1:0] q_s;
  logic signed [NEED_W-1:0] needed_calc;
  logic signed [NEED_W-1:0] remain_s;
  logic signed [NEED_W-1:0] limit_s;
  logic signed [NEED_W-1:0] excess_s;
  logic                     catch_hit;
  logic [TIME_W-1:0]        ps_catch;
  logic signed [NEED_W-1:0] diff_s;
  logic                     sleep_hit;
  logic                     diff_clamp;
  logic [RECIP_W-1:0]       recip_m;
  logic [PROD_W-1:0]        recip_prod;
  logic [DIV_D_W-1:0]       dval;
  logic [DVX_W-1:0]         qd;
  logic [DVX_W-1:0]         corr_rem;
  logic [US_W-1:0]          qc;
  logic [US_W-1:0]          delta_calc;

  frp_pkg::div_req_t div_req;
  frp_pkg::div_rsp_t div_rsp;

  assign cw       = ucode_rom(pc_r);
  assign pc_inc   = pc_r + 1'b1;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = ((cw.op == OP_EMIT_SLEEP) || (cw.op == OP_EMIT_GO)) && out_free;

  // One-second window check against the window start.
  assign win_diff = now_r - ws_r;
  assign win_hit  = (now_r >= ws_r) && (win_diff >= TIME_W'(ONE_SEC_US));
  assign ws_step  = ws_r + TIME_W'(ONE_SEC_US);

  // Time spent since the pacing start, saturated at one second.
  assign pace_diff  = now_r - ps_r;
  always_comb begin
    if (now_r < ps_r) begin
      spent_calc = '0;
    end else if (pace_diff >= TIME_W'(ONE_SEC_US)) begin
      spent_calc = ONE_SEC_US;
    end else begin
      spent_calc = pace_diff[US_W-1:0];
    end
  end

  // Numerator of the needed time as a magnitude, sign kept apart.
  assign mag      = (fc_r > CNT_W'(target_r)) ? (MAG_W'(fc_r) - MAG_W'(target_r))
                                              : (MAG_W'(target_r) - MAG_W'(fc_r));
  assign num_full = (MAG_W+US_W)'(mag) * (MAG_W+US_W)'(ONE_SEC_US);

  assign div_req.start    = (cw.op == OP_MUL);
  assign div_req.dividend = num_full[DIV_N_W-1:0];
  assign div_req.divisor  = target_r;

  frp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Signed needed time, truncated toward zero.
  assign q_s         = $signed(NEED_W'(div_rsp.quotient));
  assign needed_calc = neg_r ? -q_s : q_s;

  // Remaining time, catch-up limit and sleep decision.
  assign remain_s   = $signed(NEED_W'(ONE_SEC_US)) - $signed(NEED_W'(spent_r));
  assign limit_s    = remain_s + $signed(NEED_W'(catchup_r));
  assign catch_hit  = needed_r > limit_s;
  assign excess_s   = needed_r - limit_s;
  assign ps_catch   = ps_r + TIME_W'(excess_s[US_W:0]);
  assign sleep_hit  = remain_s > needed_r;
  assign diff_s     = remain_s - needed_r;
  assign diff_clamp = diff_s >= $signed(NEED_W'(CLAMP_LIMIT));

  // Division by five or by one thousand: reciprocal estimate, then one correction.
  assign recip_m    = (dsel_r == DSEL_MS) ? RECIP_M_MS : RECIP_M_SLEEP;
  assign recip_prod = PROD_W'(dvx_r) * PROD_W'(recip_m);
  assign dval       = (dsel_r == DSEL_MS) ? US_PER_MS : SLEEP_DIV;
  assign qd         = DVX_W'(qest_r) * DVX_W'(dval);
  assign corr_rem   = dvx_r - qd;
  assign qc         = (corr_rem >= DVX_W'(dval)) ? (qest_r + 1'b1) : qest_r;

  // Frame delta: growth of the spent time, or the previous delta.
  assign delta_calc = (spent_r > last_spent_r) ? (spent_r - last_spent_r) : last_delta_r;

  // Step sequencing.
  always_comb begin
    case (cw.cond)
      C_NEXT:       pc_nxt = pc_inc;
      C_JUMP:       pc_nxt = cw.target;
      C_WAIT_IN:    pc_nxt = (in_acc && in_ch.kind) ? pc_inc : pc_r;
      C_IF_NOTGT:   pc_nxt = (target_r == '0) ? cw.target : pc_inc;
      C_WAIT_DIV:   pc_nxt = div_rsp.busy ? pc_r : pc_inc;
      C_IF_NOCATCH: pc_nxt = catch_hit ? pc_inc : cw.target;
      C_IF_NOSLEEP: pc_nxt = sleep_hit ? pc_inc : cw.target;
      C_IF_CLAMP:   pc_nxt = clamp_r ? cw.target : pc_inc;
      C_EMIT:       pc_nxt = out_free ? cw.target : pc_r;
      default:      pc_nxt = ST_IDLE;
    endcase
  end

  // Datapath register updates driven by the current control word.
  always_comb begin
    target_nxt     = target_r;
    catchup_nxt    = catchup_r;
    ws_nxt         = ws_r;
    ps_nxt         = ps_r;
    fc_nxt         = fc_r;
    spent_nxt      = spent_r;
    last_spent_nxt = last_spent_r;
    last_delta_nxt = last_delta_r;
    ems_nxt        = ems_r;
    now_nxt        = now_r;
    fps_nxt        = fps_r;
    upd_nxt        = upd_r;
    neg_nxt        = neg_r;
    needed_nxt     = needed_r;
    dvx_nxt        = dvx_r;
    dsel_nxt       = dsel_r;
    qest_nxt       = qest_r;
    clamp_nxt      = clamp_r;
    sleep_nxt      = sleep_r;

    if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_CATCHUP) begin
        catchup_nxt = pwdata[CATCH_W-1:0];
      end else begin
        target_nxt = pwdata[FPS_W-1:0];
      end
    end

    case (cw.op)
      OP_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind) begin
            now_nxt = in_ch.now_us;
          end else if (fc_r != FC_MAX) begin
            fc_nxt = fc_r + 1'b1;
          end
        end
      end
      OP_WINDOW: begin
        fps_nxt = '0;
        upd_nxt = 1'b0;
        if (win_hit) begin
          fps_nxt = fc_r;
          upd_nxt = 1'b1;
          fc_nxt  = '0;
          ws_nxt  = ws_step;
          ps_nxt  = ws_step;
        end
      end
      OP_SPENT: begin
        spent_nxt = spent_calc;
      end
      OP_MUL: begin
        neg_nxt = fc_r > CNT_W'(target_r);
      end
      OP_NEEDED: begin
        needed_nxt = needed_calc;
      end
      OP_CATCH: begin
        if (catch_hit) begin
          ps_nxt = ps_catch;
        end
      end
      OP_SLEEPCHK: begin
        clamp_nxt = diff_clamp;
        dvx_nxt   = diff_s[DVX_W-1:0];
        dsel_nxt  = DSEL_SLEEP;
        sleep_nxt = SLEEP_MAX;
      end
      OP_RECIP: begin
        qest_nxt = recip_prod[RECIP_SHIFT +: US_W];
      end
      OP_CORR_SLEEP: begin
        sleep_nxt = (qc == '0) ? US_W'(1) : qc;
      end
      OP_DELTA: begin
        last_spent_nxt = spent_r;
        last_delta_nxt = delta_calc;
        dvx_nxt        = DVX_W'(delta_calc);
        dsel_nxt       = DSEL_MS;
      end
      OP_CORR_MS: begin
        ems_nxt = ems_r + TIME_W'(qc);
      end
      default: begin
      end
    endcase
  end

  // Result register: loads on an emit step, empties when the word is taken.
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_proceed_nxt = out_proceed_r;
    out_sleep_nxt   = out_sleep_r;
    out_delta_nxt   = out_delta_r;
    out_ems_nxt     = out_ems_r;
    out_fps_nxt     = out_fps_r;
    out_upd_nxt     = out_upd_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_ems_nxt   = ems_r;
      out_fps_nxt   = fps_r;
      out_upd_nxt   = upd_r;
      if (cw.op == OP_EMIT_GO) begin
        out_proceed_nxt = 1'b1;
        out_sleep_nxt   = '0;
        out_delta_nxt   = last_delta_r;
      end else begin
        out_proceed_nxt = 1'b0;
        out_sleep_nxt   = sleep_r;
        out_delta_nxt   = '0;
      end
    end
  end

  // Control and timing state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= TARGET_RST;
      catchup_r    <= CATCHUP_RST;
      pc_r         <= ST_IDLE;
      ws_r         <= '0;
      ps_r         <= '0;
      fc_r         <= '0;
      spent_r      <= '0;
      last_spent_r <= '0;
      last_delta_r <= '0;
      ems_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      target_r     <= target_nxt;
      catchup_r    <= catchup_nxt;
      pc_r         <= pc_nxt;
      ws_r         <= ws_nxt;
      ps_r         <= ps_nxt;
      fc_r         <= fc_nxt;
      spent_r      <= spent_nxt;
      last_spent_r <= last_spent_nxt;
      last_delta_r <= last_delta_nxt;
      ems_r        <= ems_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    fps_r         <= fps_nxt;
    upd_r         <= upd_nxt;
    neg_r         <= neg_nxt;
    needed_r      <= needed_nxt;
    dvx_r         <= dvx_nxt;
    dsel_r        <= dsel_nxt;
    qest_r        <= qest_nxt;
    clamp_r       <= clamp_nxt;
    sleep_r       <= sleep_nxt;
    out_proceed_r <= out_proceed_nxt;
    out_sleep_r   <= out_sleep_nxt;
    out_delta_r   <= out_delta_nxt;
    out_ems_r     <= out_ems_nxt;
    out_fps_r     <= out_fps_nxt;
    out_upd_r     <= out_upd_nxt;
  end

  // Channel and bus outputs.
  assign in_ch.ready        = (cw.cond == C_WAIT_IN);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.proceed     = out_proceed_r;
  assign out_ch.sleep_us    = out_sleep_r;
  assign out_ch.delta_us    = out_delta_r;
  assign out_ch.elapsed_ms  = out_ems_r;
  assign out_ch.fps         = out_fps_r;
  assign out_ch.fps_updated = out_upd_r;

  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_CATCHUP) ? APB_W'(catchup_r) : APB_W'(target_r);

  // Checks on sequencing and result values.
  `FRP_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `FRP_ASSERT_SAME(a_sleep_word, out_valid_r && !out_proceed_r, (out_sleep_r != '0) && (out_sleep_r <= SLEEP_MAX) && (out_delta_r == '0), "sleep word out of range")
  `FRP_ASSERT_SAME(a_spent_range, 1'b1, spent_r <= ONE_SEC_US, "spent time above one second")
  `FRP_ASSERT_NEXT(a_emit_go, (cw.op == OP_EMIT_GO) && out_free, out_valid_r && out_proceed_r, "proceed word not loaded")
  `FRP_ASSERT_NEXT(a_frame_inc, in_acc && !in_ch.kind && (fc_r != FC_MAX), fc_r == $past(fc_r) + 1'b1, "frame count did not advance")

endmodule

@@ bench/frp_tb_pkg.sv @@
// Shared codes, register addresses and the result word type for the pacer bench.
`timescale 1ns / 1ps

package frp_tb_pkg;
  import frp_pkg::*;

  // Kinds of input word.
  localparam logic KIND_FRAME_DONE = 1'b0;
  localparam logic KIND_PACE_CHECK = 1'b1;

  // Byte addresses of the two registers on the configuration port.
  localparam logic [PADDR_W-1:0] ADDR_TARGET  = PADDR_W'(REG_TARGET) << REG_SEL_BIT;
  localparam logic [PADDR_W-1:0] ADDR_CATCHUP = PADDR_W'(REG_CATCHUP) << REG_SEL_BIT;

  // One result word as it leaves the block.
  typedef struct packed {
    logic              proceed;
    logic [US_W-1:0]   sleep_us;
    logic [US_W-1:0]   delta_us;
    logic [TIME_W-1:0] elapsed_ms;
    logic [CNT_W-1:0]  fps;
    logic              fps_updated;
  } pace_word_t;

endpackage

@@ bench/pace_checker.sv @@
// Checker that tracks the pacer state, predicts each result word and compares it.
`timescale 1ns / 1ps

module pace_checker
  import frp_pkg::*;
  import frp_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  frp_in_if                  in_ch,
  frp_out_if                 out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  input  logic [APB_W-1:0]   prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  // Copy of the registers and of the timing state.
  logic [FPS_W-1:0]   tgt_fps;
  logic [CATCH_W-1:0] catchup;
  logic [TIME_W-1:0]  win_start;
  logic [TIME_W-1:0]  pace_origin;
  logic [CNT_W-1:0]   frames;
  logic [US_W-1:0]    spent;
  logic [US_W-1:0]    last_spent;
  logic [US_W-1:0]    last_delta;
  logic [TIME_W-1:0]  total_ms;

  pace_word_t expected_words[$];
  int         failures = 0;
  int         depth = 0;

  assign fail_count = failures;
  assign pending    = depth;

  // Time since a start point, zero if the start lies ahead, capped at one second.
  function automatic logic [US_W-1:0] span_us(input logic [TIME_W-1:0] now,
                                               input logic [TIME_W-1:0] from);
    logic [TIME_W-1:0] d;
    if (now < from) return '0;
    d = now - from;
    return (d > TIME_W'(ONE_SEC_US)) ? ONE_SEC_US : d[US_W-1:0];
  endfunction

  // Works out the result of one pace check and moves the state on.
  task automatic predict_check(input logic [TIME_W-1:0] now, output pace_word_t res);
    longint          remaining;
    longint          needed;
    longint          limit;
    longint          nap;
    logic            sleeping;
    logic [US_W-1:0] step;
    res = '0;
    sleeping = 1'b0;
    if (span_us(now, win_start) >= ONE_SEC_US) begin
      res.fps         = frames;
      res.fps_updated = 1'b1;
      frames          = '0;
      win_start       = win_start + TIME_W'(ONE_SEC_US);
      pace_origin     = win_start;
    end
    if (tgt_fps != '0) begin
      spent     = span_us(now, pace_origin);
      remaining = longint'(ONE_SEC_US) - longint'(spent);
      needed    = ((longint'(tgt_fps) - longint'(frames)) * longint'(ONE_SEC_US)) /
                  longint'(tgt_fps);
      limit     = remaining + longint'(catchup);
      // Too far behind: pull the pacing start forward by the excess.
      if (needed > limit) begin
        pace_origin = pace_origin + TIME_W'(needed - limit);
        spent       = span_us(now, pace_origin);
        remaining   = longint'(ONE_SEC_US) - longint'(spent);
      end
      if (remaining > needed) begin
        nap = (remaining - needed) / longint'(SLEEP_DIV);
        if (nap > longint'(SLEEP_MAX)) nap = longint'(SLEEP_MAX);
        if (nap < 1) nap = 1;
        res.sleep_us   = US_W'(nap);
        res.elapsed_ms = total_ms;
        sleeping       = 1'b1;
      end
    end
    // Proceed: the delta is the growth of the spent time, or the last delta again.
    if (!sleeping) begin
      step       = (spent > last_spent) ? spent - last_spent : last_delta;
      last_spent = spent;
      last_delta = step;
      total_ms   = total_ms + TIME_W'(step / US_PER_MS);
      res.proceed    = 1'b1;
      res.delta_us   = step;
      res.elapsed_ms = total_ms;
    end
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    pace_word_t want;
    pace_word_t fresh;
    if (!rst_n) begin
      tgt_fps     = TARGET_RST;
      catchup     = CATCHUP_RST;
      win_start   = '0;
      pace_origin = '0;
      frames      = '0;
      spent       = '0;
      last_spent  = '0;
      last_delta  = '0;
      total_ms    = '0;
      expected_words.delete();
    end else begin
      // Register writes and read-back on the configuration port.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[REG_SEL_BIT] == REG_TARGET) tgt_fps = pwdata[FPS_W-1:0];
          else catchup = pwdata[CATCH_W-1:0];
        end else if (paddr[REG_SEL_BIT] == REG_TARGET) begin
          check_field("target_fps readback", TIME_W'(tgt_fps), TIME_W'(prdata));
        end else begin
          check_field("catchup_us readback", TIME_W'(catchup), TIME_W'(prdata));
        end
      end

      // Result words are matched against the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction waiting");
          failures++;
        end else begin
          want = expected_words.pop_front();
          check_field("proceed", TIME_W'(want.proceed), TIME_W'(out_ch.proceed));
          check_field("sleep_us", TIME_W'(want.sleep_us), TIME_W'(out_ch.sleep_us));
          check_field("delta_us", TIME_W'(want.delta_us), TIME_W'(out_ch.delta_us));
          check_field("elapsed_ms", want.elapsed_ms, out_ch.elapsed_ms);
          check_field("fps", TIME_W'(want.fps), TIME_W'(out_ch.fps));
          check_field("fps_updated", TIME_W'(want.fps_updated),
                      TIME_W'(out_ch.fps_updated));
        end
      end

      // Accepted input words: frames bump the counter, checks give a prediction.
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_PACE_CHECK) begin
          predict_check(in_ch.now_us, fresh);
          expected_words.push_back(fresh);
        end else if (frames != FC_MAX) begin
          frames = frames + 1'b1;
        end
      end
    end
    depth <= expected_words.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the pacer bench: clock, reset, stimulus, register set-up and verdict.
`timescale 1ns / 1ps

module testbench;
  import frp_pkg::*;
  import frp_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 800;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 in_idle_pct = 0;
  int                 out_idle_pct = 0;
  bit                 hold_rx = 1'b0;

  frp_in_if  in_ch ();
  frp_out_if out_ch ();

  frame_rate_pacer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pace_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, and a long hold-off when asked for.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !hold_rx && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Offers one input word, with random gaps first, and waits until it is taken.
  task automatic send_word(input logic kind, input logic [TIME_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.now_us <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Frame-done words carry a random time that the block must ignore.
  task automatic send_frame();
    send_word(KIND_FRAME_DONE, {$urandom, $urandom});
  endtask

  // Stops offering words and waits until the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes a register and reads it straight back.
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [FPS_W-1:0]   seg_target[9];
    logic [CATCH_W-1:0] seg_catchup[9];
    logic [TIME_W-1:0]  clock_us;
    int                 step_max;
    int                 pick;

    // Every input known from the start, reset held low before release.
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_FRAME_DONE;
    in_ch.now_us = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a sleep at the minimum, then a proceed and a window close.
    in_idle_pct  = 20;
    out_idle_pct = 20;
    program_reg(ADDR_TARGET, 3);
    send_frame();
    send_word(KIND_PACE_CHECK, 64'd333331);
    send_word(KIND_PACE_CHECK, 64'd333335);
    send_word(KIND_PACE_CHECK, 64'd1000000);

    // Frame count far over target: the sleep time is clamped.
    settle();
    program_reg(ADDR_TARGET, 1);
    repeat (7) send_frame();
    send_word(KIND_PACE_CHECK, 64'd1200000);

    // Pacing disabled, with the largest time and a time behind the window.
    settle();
    program_reg(ADDR_TARGET, 0);
    send_word(KIND_PACE_CHECK, '1);
    send_word(KIND_PACE_CHECK, '0);
    send_frame();

    // Highest target with no catch-up allowance.
    settle();
    program_reg(ADDR_TARGET, 1023);
    program_reg(ADDR_CATCHUP, 0);
    send_word(KIND_PACE_CHECK, 64'h8000_0000_0000_0000);
    send_word(KIND_PACE_CHECK, 64'd2500000);

    // All-ones writes are cut to the register widths.
    settle();
    program_reg(ADDR_TARGET, '1);
    program_reg(ADDR_CATCHUP, '1);
    send_word(KIND_PACE_CHECK, 64'd3000100);
    send_frame();
    send_word(KIND_PACE_CHECK, 64'd3400000);

    // Settings for the random segments, extremes among them.
    seg_target  = '{30, 0, 1, 1000, 60, FPS_W'($urandom_range(1, 1000)), 1023, 24,
                    FPS_W'($urandom_range(1, 1000))};
    seg_catchup = '{50000, 50000, 0, 1000000, 0, CATCH_W'($urandom_range(0, 1000000)),
                    1048575, 20000, CATCH_W'($urandom_range(0, 1000000))};
    clock_us = 64'd3500000;

    for (int seg = 0; seg < 9; seg++) begin
      settle();
      // Sender slow and receiver slower, then the reverse, then no idling at all.
      case (seg / 3)
        0: begin
          in_idle_pct  = 35;
          out_idle_pct = 74;
        end
        1: begin
          in_idle_pct  = 74;
          out_idle_pct = 35;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      program_reg(ADDR_TARGET, APB_W'(seg_target[seg]));
      program_reg(ADDR_CATCHUP, APB_W'(seg_catchup[seg]));
      step_max = (seg_target[seg] != 0) ? 2000000 / seg_target[seg] : 40000;

      // Long hold-off on the result side while checks keep arriving.
      if (seg == 6) begin
        hold_rx = 1'b1;
        fork
          begin
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx = 1'b0;
          end
        join_none
        repeat (12) begin
          clock_us = clock_us + TIME_W'($urandom_range(0, step_max));
          send_word(KIND_PACE_CHECK, clock_us);
        end
      end

      // Mostly a frame loop with rising time; the rest are jumps, wild and stale times.
      repeat (47) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_frame();
        end else if (pick < 88) begin
          clock_us = clock_us + TIME_W'($urandom_range(0, step_max));
          send_word(KIND_PACE_CHECK, clock_us);
        end else if (pick < 93) begin
          clock_us = clock_us + TIME_W'($urandom_range(0, 3000000));
          send_word(KIND_PACE_CHECK, clock_us);
        end else if (pick < 97) begin
          send_word(KIND_PACE_CHECK, {$urandom, $urandom});
        end else begin
          send_word(KIND_PACE_CHECK, clock_us - TIME_W'($urandom_range(0, 2000000)));
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
